// ----- rtl/core/symmetric_2x2_eigen_solver_assert.svh -----
// Assertion macros for the 2x2 symmetric eigen solver.
// Used by the top level only; no other dependencies.
`ifndef SYMMETRIC_2X2_EIGEN_SOLVER_ASSERT_SVH
`define SYMMETRIC_2X2_EIGEN_SOLVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EIG2_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("eig2 assertion failed");

// Next-cycle implication, disabled during reset.
`define EIG2_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("eig2 assertion failed");

`endif

// ----- rtl/core/eig2_pkg.sv -----
// Package for the 2x2 symmetric eigen solver: payload types, CORDIC
// arctangent table, gain helpers and rounding. No dependencies.
`timescale 1ns / 1ps

package eig2_pkg;

  // Angle width, Q2.30 radians plus headroom
  localparam int unsigned EIG2_ZW = 34;
  // Rounded product term width
  localparam int unsigned EIG2_TW = 34;

  typedef struct packed {
    logic signed [31:0] diag_first;
    logic signed [31:0] off_diag;
    logic signed [31:0] diag_second;
  } eig2_in_t;

  typedef struct packed {
    logic signed [31:0] eig_first;
    logic signed [31:0] eig_second;
    logic signed [31:0] vec_r0c0;
    logic signed [31:0] vec_r1c0;
    logic signed [31:0] vec_r0c1;
    logic signed [31:0] vec_r1c1;
  } eig2_out_t;

  localparam logic signed [EIG2_ZW-1:0] ATAN_HEAD [10] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
    34'sd33543516, 34'sd16775851, 34'sd8388437, 34'sd4194283, 34'sd2097149
  };

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [EIG2_ZW-1:0] eig2_atan(input int i);
    logic signed [EIG2_ZW-1:0] r;
    r = '0;
    if (i < 10) begin
      r = ATAN_HEAD[i];
    end else if (i <= 30) begin
      r = EIG2_ZW'(34'sd1 <<< (30 - i));
    end
    return r;
  endfunction

  // 2^60 * prod(1 + 2^-2i), truncating each step
  function automatic longint unsigned eig2_gain_p(input int steps);
    longint unsigned p;
    p = 64'd1 << 60;
    for (int i = 0; i < steps; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    return p;
  endfunction

  // Integer square root, bitwise
  function automatic longint unsigned eig2_isqrt(input longint unsigned v);
    longint unsigned n, root, b;
    n = v;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Round half up from Q60 product to Q30
  function automatic logic signed [EIG2_TW-1:0] eig2_round30(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + 64'sd536870912) >>> 30;
    return r[EIG2_TW-1:0];
  endfunction

endpackage

// ----- rtl/core/eig2_cordic.sv -----
// Unrolled CORDIC pipeline, one register stage per iteration, vectoring or
// rotation mode. Uses eig2_pkg for the arctangent table.
`timescale 1ns / 1ps

module eig2_cordic import eig2_pkg::*; #(
  parameter int unsigned STEPS  = 24,
  parameter int unsigned XW     = 40,
  parameter int unsigned SW     = 96,
  parameter bit          VECTOR = 1'b1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [XW-1:0]      x_i,
  input  logic signed [XW-1:0]      y_i,
  input  logic signed [EIG2_ZW-1:0] z_i,
  input  logic [SW-1:0]             side_i,
  output logic                      valid_o,
  output logic signed [XW-1:0]      x_o,
  output logic signed [XW-1:0]      y_o,
  output logic signed [EIG2_ZW-1:0] z_o,
  output logic [SW-1:0]             side_o
);

  logic [STEPS-1:0]          v_q;
  logic signed [XW-1:0]      x_q [STEPS];
  logic signed [XW-1:0]      y_q [STEPS];
  logic signed [EIG2_ZW-1:0] z_q [STEPS];
  logic [SW-1:0]             s_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    localparam logic signed [EIG2_ZW-1:0] ATAN = eig2_atan(k);
    logic                      vin, up, add_x;
    logic signed [XW-1:0]      xin, yin, xs, ys, x_d, y_d;
    logic signed [EIG2_ZW-1:0] zin, z_d;
    logic [SW-1:0]             sin;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign xin = x_i;
      assign yin = y_i;
      assign zin = z_i;
      assign sin = side_i;
    end else begin : g_next
      assign vin = v_q[k-1];
      assign xin = x_q[k-1];
      assign yin = y_q[k-1];
      assign zin = z_q[k-1];
      assign sin = s_q[k-1];
    end

    // one micro-rotation; non-negative residual counts as positive
    always_comb begin
      xs = xin >>> k;
      ys = yin >>> k;
      up = VECTOR ? ~yin[XW-1] : ~zin[EIG2_ZW-1];
      add_x = VECTOR ? up : ~up;
      if (add_x) begin
        x_d = xin + ys;
        y_d = yin - xs;
        z_d = zin + ATAN;
      end else begin
        x_d = xin - ys;
        y_d = yin + xs;
        z_d = zin - ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k] <= x_d;
        y_q[k] <= y_d;
        z_q[k] <= z_d;
        s_q[k] <= sin;
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign x_o     = x_q[STEPS-1];
  assign y_o     = y_q[STEPS-1];
  assign z_o     = z_q[STEPS-1];
  assign side_o  = s_q[STEPS-1];

endmodule

// ----- rtl/core/symmetric_2x2_eigen_solver.sv -----
// Symmetric 2x2 eigen solver: Jacobi rotation angle by vectoring CORDIC,
// cos/sin by rotation CORDIC, then eigenvalue products and ordering.
// Depends on eig2_pkg, eig2_cordic and symmetric_2x2_eigen_solver_assert.svh.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one matrix (a, off, b) in
//   Q16.16 per transfer. Output channel out_valid_o/out_ready_i carries the
//   two ordered eigenvalues (Q16.16, saturated) and the eigenvector matrix
//   (Q2.30) per transfer.
//   The stages in order are one prep stage, the vectoring CORDIC, an angle
//   stage, the rotation CORDIC, a clamp stage, two multiply stages, a sum
//   stage and the output register. Throughput is one matrix per cycle
//   while the output is not stalled; each stage is one add/sub level, a set
//   of parallel 32x32 or 32x34 multiplies, or a three-term sum.
//   The whole pipeline advances together. While a result sits unaccepted in
//   the output register, the pipeline holds and in_ready_o is low; nothing
//   is dropped or repeated. An empty output register lets an item in.
//   Reset clears all valid bits; the block keeps no other state.
`timescale 1ns / 1ps

`include "symmetric_2x2_eigen_solver_assert.svh"

module symmetric_2x2_eigen_solver import eig2_pkg::*; #(
  parameter int unsigned DATA_WIDTH   = 32,
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  eig2_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output eig2_out_t out_data_o
);

  localparam int unsigned VXW = 40;
  localparam int unsigned RXW = 34;
  localparam int unsigned EW  = 36;
  localparam longint unsigned GAIN_P = eig2_gain_p(CORDIC_STEPS);
  localparam longint unsigned GAIN_S = eig2_isqrt(GAIN_P);
  localparam longint unsigned X0     = ((64'd1 << 60) + GAIN_S / 2) / GAIN_S;
  localparam logic signed [63:0] SAT_HI =
    signed'(64'hFFFF_FFFF_FFFF_FFFF >> (65 - DATA_WIDTH));
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
  localparam logic signed [RXW-1:0] Q30_ONE = RXW'(64'sd1 <<< 30);

  logic en;
  assign en = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  // prep stage: difference, start vector, equal-diagonal flag
  logic                  p_v_q, p_deq_q;
  logic signed [VXW-1:0] p_x_q, p_y_q;
  eig2_in_t              p_m_q;
  logic signed [VXW-1:0] p_d, p_y2;

  always_comb begin
    p_d  = VXW'(in_data_i.diag_first) - VXW'(in_data_i.diag_second);
    p_y2 = VXW'(in_data_i.off_diag) <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= in_valid_i & in_ready_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_x_q   <= p_d[VXW-1] ? -p_d : p_d;
      p_y_q   <= p_d[VXW-1] ? -p_y2 : p_y2;
      p_deq_q <= (in_data_i.diag_first == in_data_i.diag_second);
      p_m_q   <= in_data_i;
    end
  end

  // vectoring CORDIC: phi = atan(2 off / d)
  logic                      vc_v;
  logic signed [VXW-1:0]     vc_x, vc_y;
  logic signed [EIG2_ZW-1:0] vc_z;
  logic [96:0]               vc_side;

  eig2_cordic #(
    .STEPS  (CORDIC_STEPS),
    .XW     (VXW),
    .SW     (97),
    .VECTOR (1'b1)
  ) u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_v_q),
    .x_i     (p_x_q),
    .y_i     (p_y_q),
    .z_i     ('0),
    .side_i  ({p_deq_q, p_m_q}),
    .valid_o (vc_v),
    .x_o     (vc_x),
    .y_o     (vc_y),
    .z_o     (vc_z),
    .side_o  (vc_side)
  );

  // angle stage: theta = phi/2, or pi/4 for equal diagonals
  logic                      t_v_q;
  logic signed [EIG2_ZW-1:0] t_z_q;
  eig2_in_t                  t_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
    end else if (en) begin
      t_v_q <= vc_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_z_q <= vc_side[96] ? eig2_atan(0) : (vc_z >>> 1);
      t_m_q <= vc_side[95:0];
    end
  end

  // rotation CORDIC: cos and sin of theta
  logic                      rc_v;
  logic signed [RXW-1:0]     rc_x, rc_y;
  logic signed [EIG2_ZW-1:0] rc_z;
  eig2_in_t                  rc_m;

  eig2_cordic #(
    .STEPS  (CORDIC_STEPS),
    .XW     (RXW),
    .SW     (96),
    .VECTOR (1'b0)
  ) u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t_v_q),
    .x_i     (RXW'(X0)),
    .y_i     ('0),
    .z_i     (t_z_q),
    .side_i  (t_m_q),
    .valid_o (rc_v),
    .x_o     (rc_x),
    .y_o     (rc_y),
    .z_o     (rc_z),
    .side_o  (rc_m)
  );

  // clamp stage
  logic               c_v_q;
  logic signed [31:0] c_c_q, c_s_q;
  eig2_in_t           c_m_q;
  logic signed [RXW-1:0] c_cl, c_sl;

  always_comb begin
    c_cl = (rc_x > Q30_ONE) ? Q30_ONE : ((rc_x < -Q30_ONE) ? -Q30_ONE : rc_x);
    c_sl = (rc_y > Q30_ONE) ? Q30_ONE : ((rc_y < -Q30_ONE) ? -Q30_ONE : rc_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= rc_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_c_q <= c_cl[31:0];
      c_s_q <= c_sl[31:0];
      c_m_q <= rc_m;
    end
  end

  // first multiply stage: cc, ss, 2cs
  logic                      m1_v_q;
  logic signed [EIG2_TW-1:0] m1_cc_q, m1_ss_q, m1_sc_q;
  logic signed [31:0]        m1_c_q, m1_s_q;
  eig2_in_t                  m1_m_q;
  logic signed [63:0]        pcc, pss, pcs;

  always_comb begin
    pcc = 64'(c_c_q) * 64'(c_c_q);
    pss = 64'(c_s_q) * 64'(c_s_q);
    pcs = 64'(c_c_q) * 64'(c_s_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_cc_q <= eig2_round30(pcc);
      m1_ss_q <= eig2_round30(pss);
      m1_sc_q <= eig2_round30(pcs <<< 1);
      m1_c_q  <= c_c_q;
      m1_s_q  <= c_s_q;
      m1_m_q  <= c_m_q;
    end
  end

  // second multiply stage: entry times rotation terms
  logic                      m2_v_q;
  logic signed [EIG2_TW-1:0] m2_acc_q, m2_bss_q, m2_osc_q, m2_bcc_q, m2_ass_q;
  logic signed [31:0]        m2_c_q, m2_s_q;
  logic signed [63:0]        pacc, pbss, posc, pbcc, pass;

  always_comb begin
    pacc = 64'(m1_m_q.diag_first) * 64'(m1_cc_q);
    pbss = 64'(m1_m_q.diag_second) * 64'(m1_ss_q);
    posc = 64'(m1_m_q.off_diag) * 64'(m1_sc_q);
    pbcc = 64'(m1_m_q.diag_second) * 64'(m1_cc_q);
    pass = 64'(m1_m_q.diag_first) * 64'(m1_ss_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (en) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_acc_q <= eig2_round30(pacc);
      m2_bss_q <= eig2_round30(pbss);
      m2_osc_q <= eig2_round30(posc);
      m2_bcc_q <= eig2_round30(pbcc);
      m2_ass_q <= eig2_round30(pass);
      m2_c_q   <= m1_c_q;
      m2_s_q   <= m1_s_q;
    end
  end

  // sum stage: eigenvalues and order flag
  logic                 sm_v_q, sm_swap_q;
  logic signed [EW-1:0] sm_e0_q, sm_e1_q;
  logic signed [31:0]   sm_c_q, sm_s_q;
  logic signed [EW-1:0] e0, e1;

  always_comb begin
    e0 = EW'(m2_acc_q) + EW'(m2_bss_q) + EW'(m2_osc_q);
    e1 = EW'(m2_bcc_q) + EW'(m2_ass_q) - EW'(m2_osc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_v_q <= 1'b0;
    end else if (en) begin
      sm_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_e0_q   <= e0;
      sm_e1_q   <= e1;
      sm_swap_q <= ~(e1 > e0);
      sm_c_q    <= m2_c_q;
      sm_s_q    <= m2_s_q;
    end
  end

  // output register: ordering and saturation
  logic               o_v_q;
  eig2_out_t          o_d_q, o_d;
  logic signed [63:0] lo_e, hi_e, lo_s, hi_s;

  always_comb begin
    lo_e = sm_swap_q ? 64'(sm_e1_q) : 64'(sm_e0_q);
    hi_e = sm_swap_q ? 64'(sm_e0_q) : 64'(sm_e1_q);
    lo_s = (lo_e > SAT_HI) ? SAT_HI : ((lo_e < SAT_LO) ? SAT_LO : lo_e);
    hi_s = (hi_e > SAT_HI) ? SAT_HI : ((hi_e < SAT_LO) ? SAT_LO : hi_e);
    o_d.eig_first  = lo_s[31:0];
    o_d.eig_second = hi_s[31:0];
    if (sm_swap_q) begin
      o_d.vec_r0c0 = -sm_s_q;
      o_d.vec_r1c0 = sm_c_q;
      o_d.vec_r0c1 = sm_c_q;
      o_d.vec_r1c1 = sm_s_q;
    end else begin
      o_d.vec_r0c0 = sm_c_q;
      o_d.vec_r1c0 = sm_s_q;
      o_d.vec_r0c1 = -sm_s_q;
      o_d.vec_r1c1 = sm_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (en) begin
      o_v_q <= sm_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_d_q <= o_d;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_d_q;

  // checks
  `EIG2_ASSERT_IMP(a_vec_range, clk_i, rst_ni, out_valid_o,
    out_data_o.vec_r0c0 <= 32'sd1073741824 && out_data_o.vec_r0c0 >= -32'sd1073741824 &&
    out_data_o.vec_r1c0 <= 32'sd1073741824 && out_data_o.vec_r1c0 >= -32'sd1073741824)
  `EIG2_ASSERT_IMP(a_eig_order, clk_i, rst_ni, out_valid_o && DATA_WIDTH <= 32,
    out_data_o.eig_first <= out_data_o.eig_second)
  `EIG2_ASSERT_NXT(a_hold_on_stall, clk_i, rst_ni, sm_v_q && out_valid_o && !out_ready_i,
    sm_v_q && $stable(sm_e0_q) && $stable(sm_e1_q))

endmodule

// ----- tb/eig2_checker.sv -----
// Checker for the 2x2 symmetric eigen solver: watches both channels, predicts
// each result from the accepted matrix and compares field by field.
// Depends on eig2_pkg for the payload types.
`timescale 1ns / 1ps

module eig2_checker import eig2_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  eig2_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  eig2_out_t out_data_i,
  output int        fail_cnt_o,
  output int        pending_cnt_o,
  output int        result_cnt_o
);

  localparam int STEPS = 24;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint HALF_Q30 = 64'sd1 << 29;
  localparam longint EIG_MAX = 64'sd2147483647;
  localparam longint EIG_MIN = -64'sd2147483648;

  // atan(2^-i) in Q2.30 for the first ten steps; the rest is 2^(30-i)
  localparam longint ARCTAN_LUT [10] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149
  };

  eig2_out_t expected_q[$];
  longint    cordic_x0;

  function automatic longint arctan_step(int i);
    if (i < 10) return ARCTAN_LUT[i];
    if (i <= 30) return 64'sd1 << (30 - i);
    return 0;
  endfunction

  // Q60 product back to Q30, round half up
  function automatic longint rnd_q30(longint p);
    return (p + HALF_Q30) >>> 30;
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  function automatic longint sat_eig(longint v);
    if (v > EIG_MAX) return EIG_MAX;
    if (v < EIG_MIN) return EIG_MIN;
    return v;
  endfunction

  // Starting x of the rotation CORDIC, compensating the gain
  function automatic longint gain_inverse();
    longint unsigned gain, root, trial;
    gain = 64'd1 << 60;
    for (int i = 0; i < STEPS; i++) gain = gain + (gain >> (2 * i));
    root = 0;
    // bit-at-a-time square root, largest root with root^2 <= gain
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= gain) root = trial;
    end
    return longint'(((64'd1 << 60) + root / 2) / root);
  endfunction

  function automatic eig2_out_t predict_eigen(eig2_in_t m);
    longint a, o, b, d, x, y, z, xs, ys, theta, c, s, cc, ss, sc2, t, e0, e1;
    eig2_out_t r;
    a = m.diag_first;
    o = m.off_diag;
    b = m.diag_second;
    d = a - b;
    // rotation angle: equal diagonals give pi/4
    if (d == 0) begin
      theta = arctan_step(0);
    end else begin
      x = (d < 0) ? -d : d;
      y = (d < 0) ? -2 * o : 2 * o;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += arctan_step(i);
        end else begin
          x -= ys; y += xs; z -= arctan_step(i);
        end
      end
      theta = z >>> 1;
    end
    // cos and sin of theta
    x = cordic_x0;
    y = 0;
    z = theta;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_step(i);
      end else begin
        x += ys; y -= xs; z += arctan_step(i);
      end
    end
    c = clip_unit(x);
    s = clip_unit(y);
    cc = rnd_q30(c * c);
    ss = rnd_q30(s * s);
    sc2 = rnd_q30(2 * c * s);
    t = rnd_q30(o * sc2);
    e0 = rnd_q30(a * cc) + rnd_q30(b * ss) + t;
    e1 = rnd_q30(b * cc) + rnd_q30(a * ss) - t;
    // ordering, ties take the swapped form
    if (e1 > e0) begin
      r.eig_first = 32'(sat_eig(e0)); r.eig_second = 32'(sat_eig(e1));
      r.vec_r0c0 = 32'(c); r.vec_r1c0 = 32'(s);
      r.vec_r0c1 = 32'(-s); r.vec_r1c1 = 32'(c);
    end else begin
      r.eig_first = 32'(sat_eig(e1)); r.eig_second = 32'(sat_eig(e0));
      r.vec_r0c0 = 32'(-s); r.vec_r1c0 = 32'(c);
      r.vec_r0c1 = 32'(c); r.vec_r1c1 = 32'(s);
    end
    return r;
  endfunction

  initial cordic_x0 = gain_inverse();

  assign pending_cnt_o = expected_q.size();

  // predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    eig2_out_t exp_r;
    if (!rst_ni) begin
      expected_q.delete();
      fail_cnt_o <= 0;
      result_cnt_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_q.push_back(predict_eigen(in_data_i));
      if (out_valid_i && out_ready_i) begin
        result_cnt_o <= result_cnt_o + 1;
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r != out_data_i) fail_cnt_o <= fail_cnt_o + 1;
          if (exp_r.eig_first != out_data_i.eig_first)
            $error("eig_first exp %0d got %0d", exp_r.eig_first, out_data_i.eig_first);
          if (exp_r.eig_second != out_data_i.eig_second)
            $error("eig_second exp %0d got %0d", exp_r.eig_second, out_data_i.eig_second);
          if (exp_r.vec_r0c0 != out_data_i.vec_r0c0)
            $error("vec_r0c0 exp %0d got %0d", exp_r.vec_r0c0, out_data_i.vec_r0c0);
          if (exp_r.vec_r1c0 != out_data_i.vec_r1c0)
            $error("vec_r1c0 exp %0d got %0d", exp_r.vec_r1c0, out_data_i.vec_r1c0);
          if (exp_r.vec_r0c1 != out_data_i.vec_r0c1)
            $error("vec_r0c1 exp %0d got %0d", exp_r.vec_r0c1, out_data_i.vec_r0c1);
          if (exp_r.vec_r1c1 != out_data_i.vec_r1c1)
            $error("vec_r1c1 exp %0d got %0d", exp_r.vec_r1c1, out_data_i.vec_r1c1);
        end
      end
    end
  end

endmodule

// ----- tb/tb_symmetric_2x2_eigen_solver.sv -----
// Testbench top for the 2x2 symmetric eigen solver: clock, reset, matrix
// stimulus, output back-pressure and verdict. Depends on eig2_pkg, the
// solver RTL and eig2_checker.
`timescale 1ns / 1ps

module tb_symmetric_2x2_eigen_solver;
  import eig2_pkg::*;

  localparam int N_RANDOM = 1630;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  eig2_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  eig2_out_t out_data;
  int        fail_cnt, pending_cnt, result_cnt;
  int        sent_cnt = 0;
  int        idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  symmetric_2x2_eigen_solver DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  eig2_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_cnt_o(fail_cnt), .pending_cnt_o(pending_cnt), .result_cnt_o(result_cnt)
  );

  // offer one matrix and hold it until the transfer
  task automatic send_matrix(logic [31:0] a, logic [31:0] o, logic [31:0] b);
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data <= '{diag_first: a, off_diag: o, diag_second: b};
    do @(posedge clk_i); while (!in_ready);
    sent_cnt++;
  endtask

  task automatic drop_valid(int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // mostly moderate Q16.16 values, sometimes full range
  function automatic logic [31:0] pick_entry();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 2 * 65536 * 100)) - 65536 * 100);
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      4: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      default: return 32'($signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4);
    endcase
  endfunction

  // receiver: random stalls, free-flowing stretches and one long hold-off
  initial begin
    int phase;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      phase++;
      if (phase == 4) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end else if (phase % 3 == 0) begin
        @(negedge clk_i);
        out_ready <= 1'b1;
        repeat ($urandom_range(50, 300)) @(negedge clk_i);
      end else begin
        repeat ($urandom_range(20, 200)) begin
          @(negedge clk_i);
          out_ready <= ($urandom_range(0, 3) != 0);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int burst;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed corners: zeros, equal diagonals, extremes, ties
    send_matrix(32'h0, 32'h0, 32'h0);
    send_matrix(32'h0001_0000, 32'h0, 32'h0001_0000);
    send_matrix(32'h0002_0000, 32'h0005_0000, 32'h0002_0000);
    send_matrix(32'h0002_0000, 32'hfffb_0000, 32'h0002_0000);
    send_matrix(32'h0003_0000, 32'h0, 32'h0001_0000);
    send_matrix(32'h0001_0000, 32'h0, 32'h0003_0000);
    send_matrix(32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send_matrix(32'h0001_0000, 32'hffff_0000, 32'h0002_0000);
    send_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_matrix(32'h7fff_ffff, 32'h0, 32'h8000_0000);
    send_matrix(32'h8000_0000, 32'h0, 32'h7fff_ffff);
    send_matrix(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
    send_matrix(32'h0000_0001, 32'h7fff_ffff, 32'h0);
    send_matrix(32'h0, 32'h8000_0000, 32'h0000_0001);
    send_matrix(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_matrix(32'haaaa_aaaa, 32'h5555_5555, 32'h0);
    send_matrix(32'h0000_0001, 32'h0000_0001, 32'h0);
    drop_valid(3);

    // random part in bursts; pause midway until everything has drained
    while (sent_cnt < N_RANDOM + 20) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
      repeat (burst) begin
        if (sent_cnt < N_RANDOM + 20) begin
          if ($urandom_range(0, 9) == 0) begin
            automatic logic [31:0] dg = pick_entry();
            send_matrix(dg, pick_entry(), dg);
          end else begin
            send_matrix(pick_entry(), pick_entry(), pick_entry());
          end
        end
      end
      if (sent_cnt > 800 && sent_cnt < 1000) begin
        drop_valid(1);
        while (pending_cnt != 0) @(negedge clk_i);
      end else begin
        drop_valid($urandom_range(0, 12));
      end
    end
    drop_valid(1);

    while (pending_cnt != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Run covered %0d matrices (corners, equal diagonals, saturating values)",
             sent_cnt);
    $display("and %0d checked results under random bursts and back-pressure", result_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
